@@ hdl/assert_macros.svh @@
// assertion helpers, included by the docking sequencer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge, masked while reset is low
`define MDS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// checked on every rising edge, reset included
`define MDS_ASSERT_NR(lbl, prop) \
    lbl: assert property (@(posedge clk) (prop)) else $error("assertion failed");

`endif

@@ hdl/mds_pkg.sv @@
package mds_pkg;

    // field layout
    localparam int NFIELDS = 4;
    localparam int DIST_W  = 31;
    localparam int VEL_W   = 32;
    localparam int DT_W    = 20;
    localparam int CMD_W   = 3;
    localparam int DRV_W   = 32;
    localparam int MS_W    = 14;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W   = 32;

    // defaults for the top level parameters
    localparam int COILS_DEF      = 4;
    localparam int SETTLE_TOL_DEF = 65536;
    localparam int SIDE_B_DEF     = 0;

    // arithmetic constants
    localparam int INTEG_LIMIT = 3277;
    localparam int DRIVE_LIMIT = 131072;
    localparam int MS_MAX      = 10000;
    localparam int CURRENT_K   = 60000;

    // serial multiplier and root unit sizes
    localparam int MUL_W   = 52;
    localparam int ACC_W   = 64;
    localparam int SQ_IN_W = 34;
    localparam int SQ_OUT_W = 17;

    // command codes
    localparam logic [CMD_W-1:0] CMD_NONE    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_START   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_IDLE    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CAPTURE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CONTROL = 3'd4;
    localparam logic [CMD_W-1:0] CMD_LATCH   = 3'd5;
    localparam logic [CMD_W-1:0] CMD_UNLATCH = 3'd6;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_PROP   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_INTEG  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_VEL    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SETPOINT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LATCH_DRV   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_UNLATCH_DRV = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LATCH_DIST  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_DOCKED_DIST = 3'd7;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_CAPTURE  = 3'd1,
        PH_CONTROL  = 3'd2,
        PH_LATCH    = 3'd3,
        PH_UNLATCH  = 3'd4,
        PH_ABORT    = 3'd5,
        PH_DOCKED   = 3'd6,
        PH_UNDOCKED = 3'd7
    } phase_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic ovf;
    } mul_stat_t;

endpackage

@@ hdl/mds_mul.sv @@
// unsigned shift-add multiplier, one bit of b per cycle
module mds_mul
    import mds_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [MUL_W-1:0] a,
    input  logic [MUL_W-1:0] b,
    output logic [ACC_W-1:0] product,
    output mul_stat_t        stat
);

    logic [ACC_W-1:0] acc_reg;
    logic [ACC_W-1:0] ash_reg;
    logic             big_reg;
    logic [MUL_W-1:0] b_reg;
    logic             ovf_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [ACC_W:0]   sum;

    assign sum = {1'b0, acc_reg} + {1'b0, ash_reg};

    // accumulate shifted a for each set bit of b, sticky overflow past acc width
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            ovf_reg  <= 1'b0;
            acc_reg  <= '0;
            ash_reg  <= '0;
            big_reg  <= 1'b0;
            b_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                acc_reg  <= '0;
                ash_reg  <= {{(ACC_W-MUL_W){1'b0}}, a};
                big_reg  <= 1'b0;
                b_reg    <= b;
                ovf_reg  <= 1'b0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (b_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    if (b_reg[0])
                    begin
                        acc_reg <= sum[ACC_W-1:0];
                        if (sum[ACC_W] || big_reg)
                            ovf_reg <= 1'b1;
                    end
                    ash_reg <= {ash_reg[ACC_W-2:0], 1'b0};
                    big_reg <= big_reg | ash_reg[ACC_W-1];
                    b_reg   <= {1'b0, b_reg[MUL_W-1:1]};
                end
            end
        end
    end

    assign product   = acc_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign stat.ovf  = ovf_reg;

endmodule

@@ hdl/mds_sqrt.sv @@
// integer square root, one result bit per cycle
module mds_sqrt
    import mds_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [SQ_IN_W-1:0]  x,
    output logic [SQ_OUT_W-1:0] root,
    output logic                done
);

    localparam int RW = SQ_OUT_W + 4;
    localparam int CW = $clog2(SQ_OUT_W + 1);

    logic [SQ_IN_W-1:0]  x_reg;
    logic [RW-1:0]       rem_reg;
    logic [SQ_OUT_W-1:0] root_reg;
    logic [CW-1:0]       cnt_reg;
    logic                busy_reg;
    logic                done_reg;
    logic [RW-1:0]       rem_sh;
    logic [RW-1:0]       trial;

    assign rem_sh = {rem_reg[RW-3:0], x_reg[SQ_IN_W-1 -: 2]};
    assign trial  = {{(RW-SQ_OUT_W-2){1'b0}}, root_reg, 2'b01};

    // restoring digit recurrence, two input bits per step
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            x_reg    <= '0;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                x_reg    <= x;
                rem_reg  <= '0;
                root_reg <= '0;
                cnt_reg  <= CW'(SQ_OUT_W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (rem_sh >= trial)
                begin
                    rem_reg  <= rem_sh - trial;
                    root_reg <= {root_reg[SQ_OUT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= rem_sh;
                    root_reg <= {root_reg[SQ_OUT_W-2:0], 1'b0};
                end
                x_reg   <= {x_reg[SQ_IN_W-3:0], 2'b00};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign root = root_reg;
    assign done = done_reg;

endmodule

@@ hdl/magnetic_docking_sequencer.sv @@
// Magnetic docking sequencer, one word per control period.
// Input channel s_*: tuser carries the command, tdata the four coil distances,
// the four velocities and the step time. Output channel m_*: tuser carries the
// mode, tdata the four coil set-points, halt_all, docking_active, elapsed_ms.
// Configuration channel cfg_*: register index and data, always ready; write
// only while no word is in flight.
// Each input word yields exactly one output word. Outside the control phase an
// accepted word passes through the phase update and the done state into the
// output register. In the control phase each used coil runs up to seven
// products on one shared shift-add multiplier (one multiplier bit per cycle)
// and a square root. A new word is accepted as soon as the previous one is
// finished, even while its result still waits in the output register. If the
// receiver stalls, the next result waits until the output register empties,
// and input stays closed. Reset clears all registers: phase idle, integrator
// and set-points zero, halt_all high, docking_active low, elapsed_ms zero,
// all gains zero.
module magnetic_docking_sequencer
    import mds_pkg::*;
#(
    parameter int COILS            = COILS_DEF,
    parameter int SETTLE_TOLERANCE = SETTLE_TOL_DEF,
    parameter int SIDE_B           = SIDE_B_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // dist_coil0..3 (31 each), vel_coil0..3 (32 each), step_time (20)
    input  logic [271:0]         s_tdata,
    // command (3)
    input  logic [CMD_W-1:0]     s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // drive_coil0..3 (32 each), halt_all, docking_active, elapsed_ms (14)
    output logic [143:0]         m_tdata,
    // mode (3)
    output logic [2:0]           m_tuser,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

`include "assert_macros.svh"

    localparam int USED = (COILS < NFIELDS) ? COILS : NFIELDS;
    localparam int CNT_W = $clog2(NFIELDS + 1);
    localparam int IDX_W = $clog2(NFIELDS);
    localparam int SW = 50;
    localparam int IW = 13;
    localparam int VEL_BASE = NFIELDS * DIST_W;
    localparam int DT_BASE = VEL_BASE + NFIELDS * VEL_W;
    localparam logic signed [IW-1:0] INTEG_MAX = IW'(INTEG_LIMIT);
    localparam logic signed [IW-1:0] INTEG_MIN = -IW'(INTEG_LIMIT);
    localparam logic signed [SW-1:0] INTEG_MAX_W = SW'(INTEG_LIMIT);
    localparam logic signed [SW-1:0] INTEG_MIN_W = -SW'(INTEG_LIMIT);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PHASE,
        ST_COIL,
        ST_MUL,
        ST_SQRT,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        OP_INT,
        OP_VEL,
        OP_PROP,
        OP_INTEG,
        OP_DSQ,
        OP_K,
        OP_MAG
    } op_t;

    state_t state_reg;
    op_t    op_reg;

    // configuration
    logic signed [31:0] gain_prop_reg;
    logic signed [31:0] gain_integ_reg;
    logic signed [31:0] gain_vel_reg;
    logic [DIST_W-1:0]  setpoint_reg;
    logic [DIST_W-1:0]  latch_drv_reg;
    logic signed [31:0] unlatch_drv_reg;
    logic [DIST_W-1:0]  latch_dist_reg;
    logic [DIST_W-1:0]  docked_dist_reg;

    // captured input word
    logic [CMD_W-1:0]        cmd_reg;
    logic [DIST_W-1:0]       dist_reg [NFIELDS];
    logic signed [VEL_W-1:0] vel_reg  [NFIELDS];
    logic [DT_W-1:0]         dt_reg;

    // sequencer state
    phase_t               phase_reg;
    logic signed [IW-1:0] integ_reg;
    logic [DRV_W-1:0]     drive_reg [NFIELDS];
    logic                 halt_reg;
    logic                 active_reg;
    logic [MS_W-1:0]      ms_reg;

    // working registers
    logic [CNT_W-1:0]     coil_reg;
    logic signed [31:0]   err_reg;
    logic signed [SW-1:0] s_reg;
    logic [MUL_W-1:0]     mul_a_reg;
    logic [MUL_W-1:0]     mul_b_reg;
    logic                 mul_neg_reg;
    logic                 mul_start_reg;
    logic                 sqrt_start_reg;
    logic [SQ_IN_W-1:0]   sqrt_x_reg;

    // output register
    logic         out_valid_reg;
    logic [143:0] out_data_reg;
    logic [2:0]   out_user_reg;

    logic [ACC_W-1:0]    product;
    mul_stat_t           mul_stat;
    logic [SQ_OUT_W-1:0] root;
    logic                sqrt_done;

    mds_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start_reg),
        .a       (mul_a_reg),
        .b       (mul_b_reg),
        .product (product),
        .stat    (mul_stat)
    );

    mds_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start_reg),
        .x     (sqrt_x_reg),
        .root  (root),
        .done  (sqrt_done)
    );

    function automatic logic [31:0] abs32(input logic signed [31:0] v);
        return v[31] ? 32'(-v) : 32'(v);
    endfunction

    // signed set-point from a current magnitude and the sign of s; the sign is applied only when SIDE_B is 0
    function automatic logic [DRV_W-1:0] coil_drive(input logic [17:0] c, input logic neg);
        logic [DRV_W-1:0] m;
        m = {{(DRV_W-18){1'b0}}, c};
        if (neg && (SIDE_B == 0))
            return -m;
        return m;
    endfunction

    // forced phase, then transition rule
    logic [IDX_W-1:0]     idx;
    phase_t               forced;
    phase_t               phase_n;
    logic                 any_latch;
    logic                 all_latch;
    logic                 all_settled;
    logic                 all_docked;
    logic                 undock;
    logic signed [32:0]   e_abs;
    logic [30:0]          ms_prod;
    logic [14:0]          ms_round;
    logic [MS_W-1:0]      ms_val;
    logic [DRV_W-1:0]     latch_val;
    logic [DRV_W-1:0]     unlatch_val;

    assign idx = coil_reg[IDX_W-1:0];

    always_comb
    begin
        case (cmd_reg)
            CMD_START:   forced = PH_CONTROL;
            CMD_IDLE:    forced = PH_IDLE;
            CMD_CAPTURE: forced = PH_CAPTURE;
            CMD_CONTROL: forced = PH_CONTROL;
            CMD_LATCH:   forced = PH_LATCH;
            CMD_UNLATCH: forced = PH_UNLATCH;
            default:     forced = phase_reg;
        endcase
        undock      = setpoint_reg > latch_dist_reg;
        any_latch   = 1'b0;
        all_latch   = 1'b1;
        all_settled = 1'b1;
        all_docked  = 1'b1;
        e_abs       = '0;
        for (int i = 0; i < NFIELDS; i++)
        begin
            if (i < USED)
            begin
                e_abs = $signed({2'b00, setpoint_reg}) - $signed({2'b00, dist_reg[i]});
                if (e_abs < 0)
                    e_abs = -e_abs;
                if (dist_reg[i] <= latch_dist_reg)
                    any_latch = 1'b1;
                else
                    all_latch = 1'b0;
                if (e_abs > $signed(33'(SETTLE_TOLERANCE)))
                    all_settled = 1'b0;
                if (dist_reg[i] >= docked_dist_reg)
                    all_docked = 1'b0;
            end
        end
        case (forced)
            PH_IDLE:
                phase_n = any_latch ? (undock ? PH_UNLATCH : PH_LATCH) : PH_CONTROL;
            PH_UNLATCH:
                phase_n = any_latch ? PH_UNLATCH : PH_CONTROL;
            PH_CONTROL:
                if (undock)
                    phase_n = all_settled ? PH_UNDOCKED : PH_CONTROL;
                else
                    phase_n = all_latch ? PH_LATCH : PH_CONTROL;
            PH_LATCH:
                phase_n = all_docked ? PH_DOCKED : PH_LATCH;
            PH_DOCKED, PH_UNDOCKED, PH_ABORT:
                phase_n = PH_IDLE;
            default:
                phase_n = forced;
        endcase
    end

    // step time in ms, dt * 1000 as shifts
    assign ms_prod  = ({11'b0, dt_reg} << 10) - ({11'b0, dt_reg} << 4) - ({11'b0, dt_reg} << 3);
    assign ms_round = 15'((ms_prod + 31'd32768) >> 16);
    assign ms_val   = (ms_round > 15'(MS_MAX)) ? MS_W'(MS_MAX) : ms_round[MS_W-1:0];

    // fixed latch and unlatch currents
    always_comb
    begin
        if (SIDE_B != 0)
        begin
            latch_val = -{1'b0, latch_drv_reg};
            if (unlatch_drv_reg == 32'sh8000_0000)
                unlatch_val = 32'h7FFF_FFFF;
            else
                unlatch_val = 32'(-unlatch_drv_reg);
        end
        else
        begin
            latch_val   = {1'b0, latch_drv_reg};
            unlatch_val = unlatch_drv_reg;
        end
    end

    // product shifted right by 16 toward minus infinity, sign applied
    logic [ACC_W:0]       rnd;
    logic [ACC_W-16:0]    fs_mag;
    logic signed [SW-1:0] fs;
    logic signed [SW-1:0] isum;
    logic signed [IW-1:0] integ_clip;
    logic signed [SW-1:0] s_sum;
    logic signed [31:0]   err_w;
    logic [SW-1:0]        s_abs;
    logic                 prod_hi;

    always_comb
    begin
        rnd    = {1'b0, product} + (ACC_W+1)'(65535);
        fs_mag = mul_neg_reg ? rnd[ACC_W:16] : {1'b0, product[ACC_W-1:16]};
        fs     = mul_neg_reg ? -$signed({1'b0, fs_mag}) : $signed({1'b0, fs_mag});
        isum   = $signed({{(SW-IW){integ_reg[IW-1]}}, integ_reg}) + fs;
        if (isum > INTEG_MAX_W)
            integ_clip = INTEG_MAX;
        else if (isum < INTEG_MIN_W)
            integ_clip = INTEG_MIN;
        else
            integ_clip = isum[IW-1:0];
        s_sum   = s_reg + fs;
        err_w   = $signed({1'b0, setpoint_reg}) - $signed({1'b0, dist_reg[idx]});
        s_abs   = s_reg[SW-1] ? SW'(-s_reg) : SW'(s_reg);
        prod_hi = (product[ACC_W-1:50] != '0) || mul_stat.ovf;
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign m_tuser   = out_user_reg;

    // sequencer, datapath and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            op_reg          <= OP_INT;
            gain_prop_reg   <= '0;
            gain_integ_reg  <= '0;
            gain_vel_reg    <= '0;
            setpoint_reg    <= '0;
            latch_drv_reg   <= '0;
            unlatch_drv_reg <= '0;
            latch_dist_reg  <= '0;
            docked_dist_reg <= '0;
            cmd_reg         <= CMD_NONE;
            dt_reg          <= '0;
            for (int i = 0; i < NFIELDS; i++)
            begin
                dist_reg[i]  <= '0;
                vel_reg[i]   <= '0;
                drive_reg[i] <= '0;
            end
            phase_reg      <= PH_IDLE;
            integ_reg      <= '0;
            halt_reg       <= 1'b1;
            active_reg     <= 1'b0;
            ms_reg         <= '0;
            coil_reg       <= '0;
            err_reg        <= '0;
            s_reg          <= '0;
            mul_a_reg      <= '0;
            mul_b_reg      <= '0;
            mul_neg_reg    <= 1'b0;
            mul_start_reg  <= 1'b0;
            sqrt_start_reg <= 1'b0;
            sqrt_x_reg     <= '0;
            out_valid_reg  <= 1'b0;
            out_data_reg   <= '0;
            out_user_reg   <= '0;
        end
        else
        begin
            mul_start_reg  <= 1'b0;
            sqrt_start_reg <= 1'b0;

            // register writes
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_GAIN_PROP:   gain_prop_reg  <= cfg_data;
                    REG_GAIN_INTEG:  gain_integ_reg <= cfg_data;
                    REG_GAIN_VEL:    gain_vel_reg   <= cfg_data;
                    REG_SETPOINT:    setpoint_reg   <= cfg_data[DIST_W-1:0];
                    REG_LATCH_DRV:   latch_drv_reg  <= cfg_data[DIST_W-1:0];
                    REG_UNLATCH_DRV:
                        if ($signed(cfg_data) > 0)
                            unlatch_drv_reg <= -$signed(cfg_data);
                        else
                            unlatch_drv_reg <= cfg_data;
                    REG_LATCH_DIST:  latch_dist_reg  <= cfg_data[DIST_W-1:0];
                    REG_DOCKED_DIST: docked_dist_reg <= cfg_data[DIST_W-1:0];
                    default: ;
                endcase
            end

            // output word taken
            if (out_valid_reg && m_tready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        cmd_reg <= s_tuser;
                        for (int i = 0; i < NFIELDS; i++)
                        begin
                            dist_reg[i] <= s_tdata[i*DIST_W +: DIST_W];
                            vel_reg[i]  <= s_tdata[VEL_BASE + i*VEL_W +: VEL_W];
                        end
                        dt_reg    <= s_tdata[DT_BASE +: DT_W];
                        state_reg <= ST_PHASE;
                    end
                end

                ST_PHASE:
                begin
                    phase_reg <= phase_n;
                    state_reg <= ST_DONE;
                    if (phase_n inside {PH_IDLE, PH_ABORT, PH_LATCH, PH_UNLATCH, PH_CONTROL})
                    begin
                        ms_reg     <= ms_val;
                        halt_reg   <= (phase_n == PH_IDLE) || (phase_n == PH_ABORT);
                        active_reg <= !((phase_n == PH_IDLE) || (phase_n == PH_ABORT));
                        for (int i = 0; i < NFIELDS; i++)
                        begin
                            drive_reg[i] <= '0;
                            if (i < USED)
                            begin
                                if (phase_n == PH_LATCH)
                                    drive_reg[i] <= latch_val;
                                else if (phase_n == PH_UNLATCH)
                                    drive_reg[i] <= unlatch_val;
                            end
                        end
                        if (phase_n == PH_CONTROL)
                        begin
                            coil_reg  <= '0;
                            state_reg <= ST_COIL;
                        end
                    end
                end

                // start one coil with err * dt, or finish the word once every used coil is done
                ST_COIL:
                begin
                    if (coil_reg == CNT_W'(USED))
                        state_reg <= ST_DONE;
                    else
                    begin
                        err_reg       <= err_w;
                        mul_a_reg     <= MUL_W'(abs32(err_w));
                        mul_b_reg     <= MUL_W'(dt_reg);
                        mul_neg_reg   <= err_w[31];
                        op_reg        <= OP_INT;
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_MUL;
                    end
                end

                ST_MUL:
                begin
                    if (mul_stat.done)
                    begin
                        mul_start_reg <= 1'b1;
                        case (op_reg)
                            OP_INT:
                            begin
                                integ_reg   <= integ_clip;
                                mul_a_reg   <= MUL_W'(abs32(gain_vel_reg));
                                mul_b_reg   <= MUL_W'(abs32(vel_reg[idx]));
                                mul_neg_reg <= gain_vel_reg[31] ^ vel_reg[idx][VEL_W-1];
                                op_reg      <= OP_VEL;
                            end
                            OP_VEL:
                            begin
                                s_reg       <= -fs;
                                mul_a_reg   <= MUL_W'(abs32(gain_prop_reg));
                                mul_b_reg   <= MUL_W'(abs32(err_reg));
                                mul_neg_reg <= gain_prop_reg[31] ^ err_reg[31];
                                op_reg      <= OP_PROP;
                            end
                            OP_PROP:
                            begin
                                s_reg       <= s_sum;
                                mul_a_reg   <= MUL_W'(abs32(gain_integ_reg));
                                mul_b_reg   <= MUL_W'(abs32(32'(integ_reg)));
                                mul_neg_reg <= gain_integ_reg[31] ^ integ_reg[IW-1];
                                op_reg      <= OP_INTEG;
                            end
                            OP_INTEG:
                            begin
                                s_reg       <= s_sum;
                                mul_a_reg   <= MUL_W'(dist_reg[idx]);
                                mul_b_reg   <= MUL_W'(dist_reg[idx]);
                                mul_neg_reg <= 1'b0;
                                op_reg      <= OP_DSQ;
                                if ((s_sum == '0) || (dist_reg[idx] == '0))
                                begin
                                    mul_start_reg  <= 1'b0;
                                    drive_reg[idx] <= '0;
                                    coil_reg       <= coil_reg + 1'b1;
                                    state_reg      <= ST_COIL;
                                end
                            end
                            OP_DSQ:
                            begin
                                mul_a_reg <= product[MUL_W-1:0];
                                mul_b_reg <= MUL_W'(CURRENT_K);
                                op_reg    <= OP_K;
                                if (prod_hi)
                                begin
                                    mul_start_reg  <= 1'b0;
                                    drive_reg[idx] <= coil_drive(18'(DRIVE_LIMIT), s_reg[SW-1]);
                                    coil_reg       <= coil_reg + 1'b1;
                                    state_reg      <= ST_COIL;
                                end
                            end
                            OP_K:
                            begin
                                mul_a_reg <= product[MUL_W-1:0];
                                mul_b_reg <= MUL_W'(s_abs);
                                op_reg    <= OP_MAG;
                                if (prod_hi)
                                begin
                                    mul_start_reg  <= 1'b0;
                                    drive_reg[idx] <= coil_drive(18'(DRIVE_LIMIT), s_reg[SW-1]);
                                    coil_reg       <= coil_reg + 1'b1;
                                    state_reg      <= ST_COIL;
                                end
                            end
                            OP_MAG:
                            begin
                                mul_start_reg <= 1'b0;
                                if (prod_hi)
                                begin
                                    drive_reg[idx] <= coil_drive(18'(DRIVE_LIMIT), s_reg[SW-1]);
                                    coil_reg       <= coil_reg + 1'b1;
                                    state_reg      <= ST_COIL;
                                end
                                else
                                begin
                                    sqrt_x_reg     <= product[49:16];
                                    sqrt_start_reg <= 1'b1;
                                    state_reg      <= ST_SQRT;
                                end
                            end
                            default:
                                mul_start_reg <= 1'b0;
                        endcase
                    end
                end

                ST_SQRT:
                begin
                    if (sqrt_done)
                    begin
                        drive_reg[idx] <= coil_drive({1'b0, root}, s_reg[SW-1]);
                        coil_reg       <= coil_reg + 1'b1;
                        state_reg      <= ST_COIL;
                    end
                end

                // hand the word to the output register once it is free
                ST_DONE:
                begin
                    if (!out_valid_reg || m_tready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_user_reg  <= phase_reg;
                        for (int i = 0; i < NFIELDS; i++)
                            out_data_reg[i*DRV_W +: DRV_W] <= drive_reg[i];
                        out_data_reg[NFIELDS*DRV_W]          <= halt_reg;
                        out_data_reg[NFIELDS*DRV_W + 1]      <= active_reg;
                        out_data_reg[NFIELDS*DRV_W + 2 +: MS_W] <= ms_reg;
                        state_reg <= ST_IDLE;
                    end
                end

                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    // multiplier only runs while the sequencer waits on it
    `MDS_ASSERT(a_mul_owned, mul_stat.busy |-> (state_reg == ST_MUL))
    // a finished word reaches the output register when it is free
    `MDS_ASSERT(a_done_issues, (state_reg == ST_DONE && !out_valid_reg) |=> out_valid_reg)
    // an accepted word goes straight to the phase update
    `MDS_ASSERT(a_accept_phase, (s_tvalid && s_tready) |=> (state_reg == ST_PHASE))
    // shared integrator stays inside its clip limits
    `MDS_ASSERT_NR(a_integ_range, (integ_reg <= INTEG_MAX) && (integ_reg >= INTEG_MIN))

endmodule
